FILE: sv/rdmr_pkg.sv
// Shared types and constants for the rolling deviation mean reversion signal.
// No dependencies; imported by every module of the block except rdmr_ram.
package rdmr_pkg;

    localparam int SYMBOL_COUNT_DEF = 64;
    localparam int WINDOW_LEN_DEF   = 64;

    localparam int SYM_W   = 6;
    localparam int PRICE_W = 24;
    localparam int MID_W   = 25;
    localparam int QTY_W   = 16;
    localparam int POS_W   = 32;
    localparam int FACT_W  = 8;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 16;

    localparam logic [CIDX_W-1:0] CFG_ENTRY_FACTOR = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_EXIT_FACTOR  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ENTRY_QTY    = 2'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FILL  = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [SYM_W-1:0]   sym;
        logic               sym_ok;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [MID_W-1:0]   mid;
        logic               side;
        logic [QTY_W-1:0]   qty;
    } t_item;

    typedef struct packed {
        logic [FACT_W-1:0] entry_factor;
        logic [FACT_W-1:0] exit_factor;
        logic [QTY_W-1:0]  entry_qty;
    } t_cfg;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [POS_W-1:0]   qty;
    } t_order;

endpackage

FILE: sv/rdmr_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module rdmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/rdmr_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on rdmr_pkg.
module rdmr_front import rdmr_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [SYM_W-1:0]   i_symbol_id,
    input  logic [PRICE_W-1:0] i_bid_price,
    input  logic [PRICE_W-1:0] i_ask_price,
    input  logic               i_fill_side,
    input  logic [QTY_W-1:0]   i_fill_quantity,
    output logic               o_item_valid,
    output t_item              o_item,
    input  logic               i_item_pop
);
    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    t_item      item_in;

    // classify: symbol range check and doubled mid
    always_comb begin
        item_in.cmd    = i_command;
        item_in.sym    = i_symbol_id;
        item_in.sym_ok = (32'(i_symbol_id) < 32'(SYMBOL_COUNT));
        item_in.bid    = i_bid_price;
        item_in.ask    = i_ask_price;
        item_in.mid    = MID_W'(i_bid_price) + MID_W'(i_ask_price);
        item_in.side   = i_fill_side;
        item_in.qty    = i_fill_quantity;
    end

    assign o_ready      = i_en && (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rptr];

    // store queued requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= item_in;
        end
    end

    // advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (i_item_pop) r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(push) - 2'(i_item_pop);
        end
    end
endmodule

FILE: sv/rdmr_back.sv
// Back end: per-symbol window update, variance test and order generation.
// Depends on rdmr_pkg and rdmr_ram.
module rdmr_back import rdmr_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int WINDOW_LEN   = WINDOW_LEN_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_item_valid,
    input  t_item  i_item,
    output logic   o_item_pop,
    output logic   o_en,
    output logic   o_valid,
    input  logic   i_ready,
    output t_order o_order
);
    localparam int LW      = $clog2(WINDOW_LEN);
    localparam int SUM_W   = MID_W + LW;
    localparam int SQ_W    = 2 * MID_W + LW;
    localparam int VW      = 2 * MID_W + 2 * LW;
    localparam int CW      = VW + FACT_W;
    localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
    localparam int HEAD_W  = LW;
    localparam int SYM_AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int WIN_D   = SYMBOL_COUNT * WINDOW_LEN;
    localparam int WIN_AW  = $clog2(WIN_D);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_OLD  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_SQ   = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_DEC  = 3'd7;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [CNT_W-1:0]  cnt;
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sq;
        logic [POS_W-1:0]  pos;
    } t_sym_state;

    localparam int ST_W = $bits(t_sym_state);

    logic [2:0]          r_state, n_state;
    logic [SYM_AW-1:0]   r_clr_idx;
    t_item               r_item;
    t_sym_state          r_st;
    logic [2*MID_W-1:0]  r_msq;
    logic [WIN_AW-1:0]   r_waddr;
    logic [VW-1:0]       r_ss, r_wq, r_var, r_dsq;
    logic [SUM_W-1:0]    r_dabs;
    logic                r_above;
    logic [CW-1:0]       r_dev, r_fv;
    logic                r_out_valid;
    t_order              r_out;

    logic                st_we;
    logic [SYM_AW-1:0]   st_waddr, st_raddr;
    t_sym_state          st_wdata, st_rdata;
    logic [ST_W-1:0]     st_rbits;
    logic                win_we;
    logic [WIN_AW-1:0]   win_raddr;
    logic [MID_W-1:0]    win_rdata;

    logic                full;
    logic [2*MID_W-1:0]  old_sq;
    t_sym_state          upd;
    logic [SUM_W-1:0]    wm;
    logic [FACT_W-1:0]   factor;
    logic                out_free, hit, o_side;
    logic [POS_W-1:0]    o_qty;

    rdmr_ram #(.WIDTH(ST_W), .DEPTH(SYMBOL_COUNT)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rbits)
    );
    assign st_rdata = t_sym_state'(st_rbits);

    rdmr_ram #(.WIDTH(MID_W), .DEPTH(WIN_D)) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_waddr),
        .i_wdata (r_item.mid),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    assign o_en       = (r_state != ST_CLR);
    assign o_item_pop = (r_state == ST_IDLE) && i_item_valid;
    assign st_raddr   = SYM_AW'(i_item.sym);
    assign win_raddr  = WIN_AW'(WIN_AW'(r_item.sym) * WIN_AW'(WINDOW_LEN)
                        + WIN_AW'(st_rdata.head));
    assign win_we     = (r_state == ST_OLD);

    // window update from the stored state and the evicted sample
    always_comb begin
        full   = (32'(r_st.cnt) >= 32'(WINDOW_LEN));
        old_sq = (2*MID_W)'(win_rdata) * (2*MID_W)'(win_rdata);
        upd    = r_st;
        if (full) begin
            upd.sum = r_st.sum - SUM_W'(win_rdata) + SUM_W'(r_item.mid);
            upd.sq  = r_st.sq - SQ_W'(old_sq) + SQ_W'(r_msq);
        end else begin
            upd.sum = r_st.sum + SUM_W'(r_item.mid);
            upd.sq  = r_st.sq + SQ_W'(r_msq);
            upd.cnt = r_st.cnt + CNT_W'(1);
        end
        if (32'(r_st.head) == WINDOW_LEN - 1) upd.head = '0;
        else upd.head = r_st.head + HEAD_W'(1);
    end

    // state RAM write select: clearing pass, fill update, tick update
    always_comb begin
        st_we    = 1'b0;
        st_waddr = SYM_AW'(r_item.sym);
        st_wdata = upd;
        if (r_state == ST_CLR) begin
            st_we    = 1'b1;
            st_waddr = r_clr_idx;
            st_wdata = '0;
        end else if (r_state == ST_RD && r_item.cmd == CMD_FILL) begin
            st_we        = 1'b1;
            st_wdata     = st_rdata;
            st_wdata.pos = (r_item.side == SIDE_BUY) ? st_rdata.pos + POS_W'(r_item.qty)
                                                     : st_rdata.pos - POS_W'(r_item.qty);
        end else if (r_state == ST_OLD) begin
            st_we = 1'b1;
        end
    end

    // decision on the registered comparison operands
    always_comb begin
        wm       = SUM_W'(r_item.mid) * SUM_W'(WINDOW_LEN);
        factor   = (r_st.pos == '0) ? i_cfg.entry_factor : i_cfg.exit_factor;
        out_free = !r_out_valid || i_ready;
        o_side   = SIDE_SELL;
        o_qty    = POS_W'(i_cfg.entry_qty);
        if (r_st.pos == '0) begin
            hit    = (r_dev >= r_fv);
            o_side = r_above ? SIDE_SELL : SIDE_BUY;
        end else begin
            hit = (r_dev <= r_fv);
            if (!r_st.pos[POS_W-1]) begin
                o_side = SIDE_SELL;
                o_qty  = r_st.pos;
            end else begin
                o_side = SIDE_BUY;
                o_qty  = '0 - r_st.pos;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (32'(r_clr_idx) == SYMBOL_COUNT - 1) n_state = ST_IDLE;
            ST_IDLE: if (i_item_valid && i_item.sym_ok) n_state = ST_RD;
            ST_RD:   n_state = (r_item.cmd == CMD_FILL) ? ST_IDLE : ST_OLD;
            ST_OLD:  n_state = (32'(upd.cnt) >= 32'(WINDOW_LEN)) ? ST_MUL : ST_IDLE;
            ST_MUL:  n_state = ST_SQ;
            ST_SQ:   n_state = ST_CMP;
            ST_CMP:  n_state = ST_DEC;
            ST_DEC:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) r_clr_idx <= r_clr_idx + SYM_AW'(1);
            if (r_state == ST_DEC && out_free) r_out_valid <= hit;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_item_pop) r_item <= i_item;
        if (r_state == ST_RD) begin
            r_st    <= st_rdata;
            r_msq   <= (2*MID_W)'(r_item.mid) * (2*MID_W)'(r_item.mid);
            r_waddr <= win_raddr;
        end
        if (r_state == ST_OLD) r_st <= upd;
        if (r_state == ST_MUL) begin
            r_ss    <= VW'(r_st.sum) * VW'(r_st.sum);
            r_wq    <= VW'(r_st.sq) * VW'(WINDOW_LEN);
            r_above <= (wm >= r_st.sum);
            r_dabs  <= (wm >= r_st.sum) ? wm - r_st.sum : r_st.sum - wm;
        end
        if (r_state == ST_SQ) begin
            r_var <= (r_wq >= r_ss) ? r_wq - r_ss : '0;
            r_dsq <= VW'(r_dabs) * VW'(r_dabs);
        end
        if (r_state == ST_CMP) begin
            r_dev <= CW'(r_dsq) << 2;
            r_fv  <= CW'(r_var) * CW'(factor);
        end
        if (r_state == ST_DEC && out_free && hit) begin
            r_out.sym   <= r_item.sym;
            r_out.side  <= o_side;
            r_out.price <= (o_side == SIDE_SELL) ? r_item.bid : r_item.ask;
            r_out.qty   <= o_qty;
        end
    end

    assign o_valid = r_out_valid;
    assign o_order = r_out;
endmodule

FILE: sv/rolling_deviation_mean_reversion_signal.sv
// Rolling deviation mean reversion signal, top level.
// Once the window is full, an order follows its tick through the state RAM
// read-modify-write and the chained multiplies before it is registered.
// The back end works on one request at a time, and a 2-deep queue holds the next ones.
// Fills visit RD, ticks while the window fills RD and OLD, full-window ticks RD to DEC.
// Reset: synchronous; a clearing pass over all SYMBOL_COUNT entries zeroes per-symbol state.
// Depends on rdmr_pkg, rdmr_front, rdmr_back, rdmr_ram.
module rolling_deviation_mean_reversion_signal import rdmr_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int WINDOW_LEN   = WINDOW_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [SYM_W-1:0]   i_symbol_id,
    input  logic [PRICE_W-1:0] i_bid_price,
    input  logic [PRICE_W-1:0] i_ask_price,
    input  logic               i_fill_side,
    input  logic [QTY_W-1:0]   i_fill_quantity,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SYM_W-1:0]   o_symbol_out,
    output logic               o_order_side,
    output logic [PRICE_W-1:0] o_order_price,
    output logic [POS_W-1:0]   o_order_quantity,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDAT_W-1:0]  i_cfg_data
);
    t_cfg   r_cfg;
    logic   en, item_valid, item_pop;
    t_item  item;
    t_order order;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_factor <= FACT_W'(16);
            r_cfg.exit_factor  <= FACT_W'(1);
            r_cfg.entry_qty    <= QTY_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENTRY_FACTOR: r_cfg.entry_factor <= i_cfg_data[FACT_W-1:0];
                CFG_EXIT_FACTOR:  r_cfg.exit_factor  <= i_cfg_data[FACT_W-1:0];
                CFG_ENTRY_QTY:    r_cfg.entry_qty    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rdmr_front #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_symbol_id     (i_symbol_id),
        .i_bid_price     (i_bid_price),
        .i_ask_price     (i_ask_price),
        .i_fill_side     (i_fill_side),
        .i_fill_quantity (i_fill_quantity),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_pop      (item_pop)
    );

    rdmr_back #(.SYMBOL_COUNT(SYMBOL_COUNT), .WINDOW_LEN(WINDOW_LEN)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_en         (en),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_order      (order)
    );

    assign o_symbol_out     = order.sym;
    assign o_order_side     = order.side;
    assign o_order_price    = order.price;
    assign o_order_quantity = order.qty;
endmodule
